@@ hdl/uvst_pkg.sv @@
package uvst_pkg;

   localparam int FRAC_BITS = 15;
   localparam int Q30_SHIFT = 30;
   localparam logic signed [33:0] Q30_ONE = 34'sd1073741824;
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

   // Horner coefficient ratios, innermost first
   localparam int NUM_COS_STEPS = 6;
   localparam int NUM_SIN_STEPS = 5;
   localparam int COS_DIV [NUM_COS_STEPS] = '{132, 90, 56, 30, 12, 2};
   localparam int SIN_DIV [NUM_SIN_STEPS] = '{110, 72, 42, 20, 6};
   localparam int RECIP_SHIFT = 34;

   // sin/cos unit: angle, square, three stages per Horner step, quadrant fold
   localparam int SC_LATENCY = 3 + 3 * NUM_COS_STEPS;
   // front end (capture, products, reciprocal, phase), unit, product, output
   localparam int LATENCY = SC_LATENCY + 6;

   localparam int SUBDIV_MIN = 3;
   localparam logic [6:0] SUBDIV_RESET = 7'd24;

   typedef enum logic [2:0] {
      CSR_ADDR_SUBDIV = 3'd0
   } csr_addr_type;

   typedef struct packed {
      logic [6:0] ring;
      logic [6:0] segment;
   } req_type;

   typedef struct packed {
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic [15:0] tex_u;
      logic [15:0] tex_v;
      logic has_quad;
      logic [12:0] corner_a;
      logic [12:0] corner_b;
      logic [12:0] corner_c;
      logic [12:0] corner_d;
      logic range_error;
   } rsp_type;

   typedef struct packed {
      logic signed [33:0] x2;
      logic signed [33:0] a;
      logic [1:0] quad;
   } sc_carry_type;

   typedef struct packed {
      logic [15:0] tex_u;
      logic [15:0] tex_v;
      logic has_quad;
      logic [12:0] corner_a;
      logic [12:0] corner_b;
      logic [12:0] corner_c;
      logic [12:0] corner_d;
      logic range_error;
   } sideband_type;

endpackage

@@ hdl/uvst_sincos.sv @@
module uvst_sincos (
   input  logic        clock,
   input  logic [31:0] phase,
   output logic [30:0] sin_mag,
   output logic        sin_neg,
   output logic [30:0] cos_mag,
   output logic        cos_neg
);
   import uvst_pkg::*;

   // Q30 product truncated toward zero
   function automatic logic signed [39:0] mul_q30(input logic signed [33:0] x,
                                                  input logic signed [33:0] y);
      logic signed [67:0] prod;
      logic [67:0] mag;
      logic signed [39:0] m;
      prod = 68'(x) * 68'(y);
      mag = prod[67] ? 68'(-prod) : 68'(prod);
      m = $signed({2'b00, mag[67:30]});
      return prod[67] ? -m : m;
   endfunction

   function automatic logic [30:0] clamp_q30(input logic signed [39:0] v);
      logic [30:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > 40'(Q30_ONE)) begin
         r = 31'(Q30_ONE);
      end else begin
         r = v[30:0];
      end
      return r;
   endfunction

   logic signed [33:0] a_ff;
   logic [1:0] quad1_ff;
   sc_carry_type carry0_ff;
   logic [60:0] ang_prod;
   logic [61:0] sq_prod;

   sc_carry_type carry_in_w [NUM_COS_STEPS];
   sc_carry_type carry_a_ff [NUM_COS_STEPS];
   sc_carry_type carry_b_ff [NUM_COS_STEPS];
   sc_carry_type carry_c_ff [NUM_COS_STEPS];

   logic signed [39:0] cos_p_ff [NUM_COS_STEPS];
   logic [32:0] cos_y_ff [NUM_COS_STEPS];
   logic [32:0] cos_q0_ff [NUM_COS_STEPS];
   logic cos_n_ff [NUM_COS_STEPS];
   logic signed [33:0] cos_t_ff [NUM_COS_STEPS];

   logic signed [39:0] sin_p_ff [NUM_SIN_STEPS];
   logic [32:0] sin_y_ff [NUM_SIN_STEPS];
   logic [32:0] sin_q0_ff [NUM_SIN_STEPS];
   logic sin_n_ff [NUM_SIN_STEPS];
   logic signed [33:0] sin_t_ff [NUM_SIN_STEPS];

   logic signed [39:0] sin_fp_ff;
   logic [30:0] sin_fm_ff;
   logic [30:0] sin_fm2_ff;

   logic [30:0] cos_clamped;
   logic [1:0] quad_out;

   assign ang_prod = 61'(phase[29:0]) * 61'(HALF_PI_Q30);
   assign sq_prod = 62'(a_ff[30:0]) * 62'(a_ff[30:0]);

   always_ff @(posedge clock) begin
      a_ff <= $signed({3'b000, ang_prod[60:30]});
      quad1_ff <= phase[31:30];
      carry0_ff.x2 <= $signed({2'b00, sq_prod[61:30]});
      carry0_ff.a <= a_ff;
      carry0_ff.quad <= quad1_ff;
   end

   for (genvar k = 0; k < NUM_COS_STEPS; k++) begin : g_cos
      localparam int D = COS_DIV[k];
      localparam logic [34:0] M = 35'((64'd1 << RECIP_SHIFT) / D);
      logic signed [33:0] t_in;
      logic [39:0] p_mag;
      logic [67:0] ym;
      logic [40:0] rem;
      logic [32:0] q;

      if (k == 0) begin : g_first
         assign carry_in_w[k] = carry0_ff;
         assign t_in = Q30_ONE;
      end else begin : g_next
         assign carry_in_w[k] = carry_c_ff[k-1];
         assign t_in = cos_t_ff[k-1];
      end

      always_comb begin
         p_mag = cos_p_ff[k][39] ? 40'(-cos_p_ff[k]) : 40'(cos_p_ff[k]);
         ym = 68'(p_mag[32:0]) * 68'(M);
         rem = 41'(cos_y_ff[k]) - 41'(cos_q0_ff[k]) * 41'(D);
         q = (rem >= 41'(D)) ? cos_q0_ff[k] + 33'd1 : cos_q0_ff[k];
      end

      always_ff @(posedge clock) begin
         cos_p_ff[k] <= mul_q30(carry_in_w[k].x2, t_in);
         carry_a_ff[k] <= carry_in_w[k];
         cos_y_ff[k] <= p_mag[32:0];
         cos_q0_ff[k] <= ym[66:34];
         cos_n_ff[k] <= cos_p_ff[k][39];
         carry_b_ff[k] <= carry_a_ff[k];
         cos_t_ff[k] <= cos_n_ff[k] ? Q30_ONE + $signed({1'b0, q})
                                    : Q30_ONE - $signed({1'b0, q});
         carry_c_ff[k] <= carry_b_ff[k];
      end
   end

   for (genvar k = 0; k < NUM_SIN_STEPS; k++) begin : g_sin
      localparam int D = SIN_DIV[k];
      localparam logic [34:0] M = 35'((64'd1 << RECIP_SHIFT) / D);
      logic signed [33:0] t_in;
      logic [39:0] p_mag;
      logic [67:0] ym;
      logic [40:0] rem;
      logic [32:0] q;

      if (k == 0) begin : g_first
         assign t_in = Q30_ONE;
      end else begin : g_next
         assign t_in = sin_t_ff[k-1];
      end

      always_comb begin
         p_mag = sin_p_ff[k][39] ? 40'(-sin_p_ff[k]) : 40'(sin_p_ff[k]);
         ym = 68'(p_mag[32:0]) * 68'(M);
         rem = 41'(sin_y_ff[k]) - 41'(sin_q0_ff[k]) * 41'(D);
         q = (rem >= 41'(D)) ? sin_q0_ff[k] + 33'd1 : sin_q0_ff[k];
      end

      always_ff @(posedge clock) begin
         sin_p_ff[k] <= mul_q30(carry_in_w[k].x2, t_in);
         sin_y_ff[k] <= p_mag[32:0];
         sin_q0_ff[k] <= ym[66:34];
         sin_n_ff[k] <= sin_p_ff[k][39];
         sin_t_ff[k] <= sin_n_ff[k] ? Q30_ONE + $signed({1'b0, q})
                                    : Q30_ONE - $signed({1'b0, q});
      end
   end

   // final sin multiply runs beside the last cos step
   always_ff @(posedge clock) begin
      sin_fp_ff <= mul_q30(carry_in_w[NUM_SIN_STEPS].a, sin_t_ff[NUM_SIN_STEPS-1]);
      sin_fm_ff <= clamp_q30(sin_fp_ff);
      sin_fm2_ff <= sin_fm_ff;
   end

   assign cos_clamped = clamp_q30(40'(cos_t_ff[NUM_COS_STEPS-1]));
   assign quad_out = carry_c_ff[NUM_COS_STEPS-1].quad;

   always_ff @(posedge clock) begin
      case (quad_out)
         2'd0: begin
            sin_mag <= sin_fm2_ff;  sin_neg <= 1'b0;
            cos_mag <= cos_clamped; cos_neg <= 1'b0;
         end
         2'd1: begin
            sin_mag <= cos_clamped; sin_neg <= 1'b0;
            cos_mag <= sin_fm2_ff;  cos_neg <= 1'b1;
         end
         2'd2: begin
            sin_mag <= sin_fm2_ff;  sin_neg <= 1'b1;
            cos_mag <= cos_clamped; cos_neg <= 1'b1;
         end
         default: begin
            sin_mag <= cos_clamped; sin_neg <= 1'b1;
            cos_mag <= sin_fm2_ff;  cos_neg <= 1'b0;
         end
      endcase
   end

endmodule

@@ hdl/uv_sphere_tessellator.sv @@
// UV sphere vertex unit. Each word (ring, segment) yields one result word with
// position (also the normal) in Q1.15, texture u/v, quad corner indices, and a
// range flag. The pipeline takes a word every cycle; the result path runs through
// the 21-stage sin/cos unit and its Horner steps. Results cannot be held off, so
// rsp_valid is a one-cycle strobe. busy is high only during reset. subdivision
// is clamped to 3..MAX_SUBDIVISION. The user must write subdivision over the
// register port only while no words are in flight; the block does not enforce it.
module uv_sphere_tessellator #(
   parameter int MAX_SUBDIVISION = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  uvst_pkg::req_type req_data,
   output logic             rsp_valid,
   output uvst_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import uvst_pkg::*;

   localparam int NUM_N = 128;
   localparam int SB_DEPTH = SC_LATENCY + 3;
   localparam int XY_SHIFT = 60 - FRAC_BITS;
   localparam int Z_SHIFT = 30 - FRAC_BITS;
   localparam logic [15:0] MAX_CODE = 16'((32'd1 << FRAC_BITS) - 1);

   function automatic logic [15:0] code_xy(input logic [61:0] mag, input logic neg);
      logic [62:0] sum;
      logic [62-XY_SHIFT:0] r;
      logic [62-XY_SHIFT:0] nr;
      logic [15:0] c;
      sum = {1'b0, mag} + (63'd1 << (XY_SHIFT - 1));
      r = sum[62:XY_SHIFT];
      nr = -r;
      if (neg) begin
         c = nr[15:0];
      end else if (r > (62-XY_SHIFT+1)'(MAX_CODE)) begin
         c = MAX_CODE;
      end else begin
         c = r[15:0];
      end
      return c;
   endfunction

   function automatic logic [15:0] code_z(input logic [30:0] mag, input logic neg);
      logic [31:0] sum;
      logic [31-Z_SHIFT:0] r;
      logic [31-Z_SHIFT:0] nr;
      logic [15:0] c;
      sum = {1'b0, mag} + (32'd1 << (Z_SHIFT - 1));
      r = sum[31:Z_SHIFT];
      nr = -r;
      if (neg) begin
         c = nr[15:0];
      end else if (r > (31-Z_SHIFT+1)'(MAX_CODE)) begin
         c = MAX_CODE;
      end else begin
         c = r[15:0];
      end
      return c;
   endfunction

   // register port
   logic [6:0] subdiv_ff;
   logic csr_write;
   logic [6:0] n_eff;

   assign csr_write = psel & penable & pwrite & (paddr == CSR_ADDR_SUBDIV);
   assign pready = 1'b1;
   assign prdata = (paddr == CSR_ADDR_SUBDIV) ? 32'(subdiv_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         subdiv_ff <= SUBDIV_RESET;
      end else if (csr_write) begin
         subdiv_ff <= pwdata[6:0];
      end
   end

   always_comb begin
      if (subdiv_ff < 7'(SUBDIV_MIN)) begin
         n_eff = 7'(SUBDIV_MIN);
      end else if ({1'b0, subdiv_ff} > 8'(MAX_SUBDIVISION)) begin
         n_eff = 7'(MAX_SUBDIVISION);
      end else begin
         n_eff = subdiv_ff;
      end
   end

   // 2^32 / den split into quotient and remainder, per count
   logic [31:0] tbl_qt [NUM_N];
   logic [7:0] tbl_rt [NUM_N];
   logic [31:0] tbl_qp [NUM_N];
   logic [7:0] tbl_rp [NUM_N];

   for (genvar g = 0; g < NUM_N; g++) begin : g_tbl
      localparam longint NV = (g < SUBDIV_MIN) ? SUBDIV_MIN : g;
      localparam longint TWO32 = 64'sh1_0000_0000;
      localparam longint QT = TWO32 / (2 * NV);
      localparam longint RT = TWO32 - QT * 2 * NV;
      localparam longint QP = TWO32 / NV;
      localparam longint RP = TWO32 - QP * NV;
      assign tbl_qt[g] = 32'(QT);
      assign tbl_rt[g] = 8'(RT);
      assign tbl_qp[g] = 32'(QP);
      assign tbl_rp[g] = 8'(RP);
   end

   logic accept;
   assign busy = reset;
   assign accept = start & ~busy;

   // stage 0: capture
   logic vld0_ff;
   logic [6:0] r0_ff, s0_ff, n0_ff;
   logic err0_ff, hq0_ff;
   logic [31:0] qt0_ff, qp0_ff;
   logic [7:0] rt0_ff, rp0_ff;
   logic err_in, hq_in;

   assign err_in = (req_data.ring > n_eff) || (req_data.segment > n_eff);
   assign hq_in = (req_data.ring < n_eff) && (req_data.segment < n_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
      end else begin
         vld0_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      r0_ff <= req_data.ring;
      s0_ff <= req_data.segment;
      n0_ff <= n_eff;
      err0_ff <= err_in;
      hq0_ff <= hq_in;
      qt0_ff <= tbl_qt[n_eff];
      rt0_ff <= tbl_rt[n_eff];
      qp0_ff <= tbl_qp[n_eff];
      rp0_ff <= tbl_rp[n_eff];
   end

   // stage 1: integer products
   logic vld1_ff;
   logic [31:0] bt1_ff, bp1_ff;
   logic [14:0] xt1_ff, xp1_ff;
   logic [32:0] qt1_ff, qp1_ff;
   logic [22:0] nu1_ff, nv1_ff;
   logic [12:0] ca1_ff, cb1_ff, cc1_ff, cd1_ff;
   logic hq1_ff, err1_ff;
   logic [38:0] bt_in, bp_in;
   logic [7:0] w_in;
   logic [15:0] ra_in, ca_in, cb_in;

   always_comb begin
      bt_in = 39'(r0_ff) * 39'(qt0_ff);
      bp_in = 39'(s0_ff) * 39'(qp0_ff);
      w_in = 8'(n0_ff) + 8'd1;
      ra_in = 16'(r0_ff) * 16'(w_in);
      ca_in = ra_in + 16'(s0_ff);
      cb_in = ca_in + 16'(w_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else begin
         vld1_ff <= vld0_ff;
      end
   end

   always_ff @(posedge clock) begin
      bt1_ff <= bt_in[31:0];
      bp1_ff <= bp_in[31:0];
      xt1_ff <= 15'(r0_ff) * 15'(rt0_ff);
      xp1_ff <= 15'(s0_ff) * 15'(rp0_ff);
      qt1_ff <= 33'(qt0_ff) + 33'd1;
      qp1_ff <= 33'(qp0_ff) + 33'd1;
      nu1_ff <= 23'({s0_ff, 15'd0}) + 23'(n0_ff >> 1);
      nv1_ff <= 23'({7'(n0_ff - r0_ff), 15'd0}) + 23'(n0_ff >> 1);
      ca1_ff <= hq0_ff ? ca_in[12:0] : 13'd0;
      cb1_ff <= hq0_ff ? cb_in[12:0] : 13'd0;
      cc1_ff <= hq0_ff ? 13'(cb_in + 16'd1) : 13'd0;
      cd1_ff <= hq0_ff ? 13'(ca_in + 16'd1) : 13'd0;
      hq1_ff <= hq0_ff;
      err1_ff <= err0_ff;
   end

   // stage 2: reciprocal products for the remainders and texture coords
   logic [31:0] bt2_ff, bp2_ff;
   logic [7:0] frt2_ff, frp2_ff;
   logic [47:0] frt_in, frp_in;
   logic [55:0] tu_in, tv_in;
   sideband_type sb_in;

   always_comb begin
      frt_in = 48'(xt1_ff) * 48'(qt1_ff);
      frp_in = 48'(xp1_ff) * 48'(qp1_ff);
      tu_in = 56'(nu1_ff) * 56'(qp1_ff);
      tv_in = 56'(nv1_ff) * 56'(qp1_ff);
      sb_in.tex_u = tu_in[47:32];
      sb_in.tex_v = tv_in[47:32];
      sb_in.has_quad = hq1_ff;
      sb_in.corner_a = ca1_ff;
      sb_in.corner_b = cb1_ff;
      sb_in.corner_c = cc1_ff;
      sb_in.corner_d = cd1_ff;
      sb_in.range_error = err1_ff;
   end

   always_ff @(posedge clock) begin
      bt2_ff <= bt1_ff;
      bp2_ff <= bp1_ff;
      frt2_ff <= frt_in[39:32];
      frp2_ff <= frp_in[39:32];
   end

   // stage 3: phase words
   logic [31:0] ph_t_ff, ph_p_ff;

   always_ff @(posedge clock) begin
      ph_t_ff <= bt2_ff + 32'(frt2_ff);
      ph_p_ff <= bp2_ff + 32'(frp2_ff);
   end

   logic [30:0] st, ct, sp, cp;
   logic stn, ctn, spn, cpn;

   uvst_sincos u_theta (
      .clock   (clock),
      .phase   (ph_t_ff),
      .sin_mag (st),
      .sin_neg (stn),
      .cos_mag (ct),
      .cos_neg (ctn)
   );

   uvst_sincos u_phi (
      .clock   (clock),
      .phase   (ph_p_ff),
      .sin_mag (sp),
      .sin_neg (spn),
      .cos_mag (cp),
      .cos_neg (cpn)
   );

   // sideband rides alongside the sin/cos unit
   sideband_type sb_ff [SB_DEPTH];
   logic sb_vld_ff [SB_DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SB_DEPTH; i++) begin
            sb_vld_ff[i] <= 1'b0;
         end
      end else begin
         sb_vld_ff[0] <= vld1_ff;
         for (int i = 1; i < SB_DEPTH; i++) begin
            sb_vld_ff[i] <= sb_vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      sb_ff[0] <= sb_in;
      for (int i = 1; i < SB_DEPTH; i++) begin
         sb_ff[i] <= sb_ff[i-1];
      end
   end

   // position products
   logic [61:0] px_ff, py_ff;
   logic pxn_ff, pyn_ff, zn_ff;
   logic [30:0] zm_ff;

   always_ff @(posedge clock) begin
      px_ff <= 62'(st) * 62'(cp);
      py_ff <= 62'(st) * 62'(sp);
      pxn_ff <= stn ^ cpn;
      pyn_ff <= stn ^ spn;
      zm_ff <= ct;
      zn_ff <= ctn;
   end

   // output word
   logic rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;
   sideband_type sb_last;

   assign sb_last = sb_ff[SB_DEPTH-1];

   always_comb begin
      if (sb_last.range_error) begin
         rsp_in = '0;
         rsp_in.range_error = 1'b1;
      end else begin
         rsp_in.pos_x = code_xy(px_ff, pxn_ff);
         rsp_in.pos_y = code_xy(py_ff, pyn_ff);
         rsp_in.pos_z = code_z(zm_ff, zn_ff);
         rsp_in.tex_u = sb_last.tex_u;
         rsp_in.tex_v = sb_last.tex_v;
         rsp_in.has_quad = sb_last.has_quad;
         rsp_in.corner_a = sb_last.corner_a;
         rsp_in.corner_b = sb_last.corner_b;
         rsp_in.corner_c = sb_last.corner_c;
         rsp_in.corner_d = sb_last.corner_d;
         rsp_in.range_error = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= sb_vld_ff[SB_DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

@@ hdl/uvst_checker.sv @@
module uvst_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input uvst_pkg::rsp_type rsp_data
);
   import uvst_pkg::*;

   localparam int CW = $clog2(LATENCY + 1);

   logic [CW-1:0] warm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         warm_ff <= '0;
      end else if (warm_ff != CW'(LATENCY)) begin
         warm_ff <= warm_ff + CW'(1);
      end
   end

   // one result word per accepted word, fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (warm_ff == CW'(LATENCY)) |-> (rsp_valid == $past(start && !busy, LATENCY)))
      else $error("result strobe does not match accepted words");

   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.range_error) |->
         (rsp_data.pos_x == 16'sd0 && rsp_data.pos_y == 16'sd0 &&
          rsp_data.pos_z == 16'sd0 && rsp_data.tex_u == 16'd0 &&
          rsp_data.tex_v == 16'd0 && !rsp_data.has_quad &&
          rsp_data.corner_a == 13'd0 && rsp_data.corner_d == 13'd0))
      else $error("range error word carries nonzero fields");

   a_quad_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.has_quad) |->
         (!rsp_data.range_error &&
          rsp_data.corner_c == 13'(rsp_data.corner_b + 13'd1) &&
          rsp_data.corner_d == 13'(rsp_data.corner_a + 13'd1)))
      else $error("quad corners inconsistent");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_valid && busy == reset))
      else $error("strobe or busy wrong after reset");

endmodule

bind uv_sphere_tessellator uvst_checker u_uvst_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
